// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; every macro disables itself while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define AST_SAME(lbl, clk, rstn, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
    else $error("assertion failed");

// Condition must hold in the cycle after the trigger.
`define AST_NEXT(lbl, clk, rstn, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// ----- rtl/mrcc_pkg.sv -----
// Types and constants for the Modbus RTU frame CRC check.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mrcc_pkg;

  localparam int CNT_W = 9;

  localparam logic [CNT_W-1:0] CNT_MAX  = 9'd511;
  localparam logic [CNT_W-1:0] LEN_POS  = 9'd2;
  localparam logic [9:0]       HDR_BYTES  = 10'd3;
  localparam logic [9:0]       MIN_BYTES  = 10'd3;
  localparam logic [9:0]       TAIL_BYTES = 10'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] computed_crc;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mrcc_in_reg.sv -----
// Input register of the frame CRC check: holds one item until the frame logic takes it.
// Depends on mrcc_pkg.
`default_nettype none

module mrcc_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mrcc_pkg::item_t in_item,
  input  wire logic          adv,
  output logic               stage_valid,
  output mrcc_pkg::item_t    stage_item
);

  logic            valid_r;
  mrcc_pkg::item_t item_r;

  assign in_ready    = !valid_r || adv;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mrcc_frame.sv -----
// Frame state and per-byte update: length capture, CRC-16 update, received CRC, status.
// Depends on mrcc_pkg.
`default_nettype none

module mrcc_frame (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire mrcc_pkg::item_t item,
  output mrcc_pkg::result_t    res
);

  logic [mrcc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [15:0]                rcv_r, rcv_nxt;

  logic [7:0]  len_eff;
  logic [9:0]  idx;
  logic [9:0]  crc_end;
  logic [9:0]  n_bytes;
  logic        crc_en;
  logic        short_frame;
  logic [15:0] crc_upd;
  logic [15:0] rcv_upd;
  logic [15:0] crc_swap;

  always_comb begin
    len_eff  = (cnt_r == mrcc_pkg::LEN_POS) ? item.data_byte : len_r;
    idx      = {1'b0, cnt_r};
    crc_end  = {2'b00, len_eff} + mrcc_pkg::HDR_BYTES;
    n_bytes  = idx + 10'd1;
    crc_en   = (cnt_r <= mrcc_pkg::LEN_POS) || (idx < crc_end);
    crc_upd  = crc_r;
    rcv_upd  = rcv_r;
    if (crc_en) begin
      crc_upd = mrcc_pkg::crc_byte(crc_r, item.data_byte);
    end else if (idx == crc_end) begin
      rcv_upd = {item.data_byte, 8'h00};
    end else if (idx == crc_end + 10'd1) begin
      rcv_upd = {rcv_r[15:8], item.data_byte};
    end
    crc_swap    = {crc_upd[7:0], crc_upd[15:8]};
    short_frame = (n_bytes < mrcc_pkg::MIN_BYTES) ||
                  (n_bytes < {2'b00, len_eff} + mrcc_pkg::TAIL_BYTES);
    if (short_frame) begin
      res.status       = mrcc_pkg::ST_SHORT;
      res.computed_crc = 16'h0000;
    end else if (crc_swap == rcv_upd) begin
      res.status       = mrcc_pkg::ST_OK;
      res.computed_crc = crc_swap;
    end else begin
      res.status       = mrcc_pkg::ST_MISMATCH;
      res.computed_crc = crc_swap;
    end
  end

  always_comb begin
    if (item.last_byte) begin
      cnt_nxt = '0;
      len_nxt = 8'h00;
      crc_nxt = mrcc_pkg::CRC_INIT;
      rcv_nxt = 16'h0000;
    end else begin
      cnt_nxt = (cnt_r < mrcc_pkg::CNT_MAX) ? cnt_r + 9'd1 : cnt_r;
      len_nxt = len_eff;
      crc_nxt = crc_upd;
      rcv_nxt = rcv_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      len_r <= 8'h00;
      crc_r <= mrcc_pkg::CRC_INIT;
      rcv_r <= 16'h0000;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      rcv_r <= rcv_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mrcc_out_reg.sv -----
// Result register of the frame CRC check: holds one result until it is taken.
// Depends on mrcc_pkg.
`default_nettype none

module mrcc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire mrcc_pkg::result_t res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mrcc_pkg::result_t      out_res
);

  logic              valid_r;
  mrcc_pkg::result_t res_r;

  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_frame_crc_check.sv -----
// Modbus RTU frame check, top level: input register, frame logic, result register.
// Depends on mrcc_pkg, mrcc_in_reg, mrcc_frame, mrcc_out_reg.
//
// Takes one received byte per cycle unless stalled, with no gaps between frames.
// Byte 2 of a frame is the data length L; CRC-16/MODBUS covers bytes 0..L+2, bytes
// L+3 and L+4 are the received CRC (low byte first), later bytes are ignored. On
// the byte flagged last, one result item carries the status (ok, too short, CRC
// mismatch) and the computed CRC (zero if too short), first transmitted byte in
// bits 15..8; the frame state then clears. A result passes through the input
// register, then through the byte-wide CRC update into the result register.
// Bytes keep flowing while a result waits; only a second last byte stalls until
// the waiting result is taken.
`default_nettype none

module modbus_rtu_frame_crc_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_computed_crc
);

  mrcc_pkg::item_t   in_item;
  mrcc_pkg::item_t   stage_item;
  mrcc_pkg::result_t frame_res;
  mrcc_pkg::result_t out_res;
  logic              stage_valid;
  logic              adv;
  logic              fire;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  assign adv  = !(stage_item.last_byte && out_valid && !out_ready);
  assign fire = stage_valid && adv;

  assign out_status       = out_res.status;
  assign out_computed_crc = out_res.computed_crc;

  mrcc_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .adv         (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  mrcc_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (stage_item),
    .res   (frame_res)
  );

  mrcc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && stage_item.last_byte),
    .res       (frame_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

// ----- rtl/mrcc_checker.sv -----
// Port-level checks for the Modbus RTU frame CRC check, bound to the top level.
// Depends on assert_macros.svh and mrcc_pkg.
`default_nettype none
`include "assert_macros.svh"

module mrcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_computed_crc
);

  logic stall_out;
  logic status_legal;

  assign stall_out    = out_valid && !out_ready;
  assign status_legal = out_status inside {mrcc_pkg::ST_OK, mrcc_pkg::ST_SHORT,
                                           mrcc_pkg::ST_MISMATCH};

  `AST_NEXT(a_out_hold, clk, rst_n, stall_out, out_valid)
  `AST_NEXT(a_out_stable, clk, rst_n, stall_out, $stable(out_status) && $stable(out_computed_crc))
  `AST_SAME(a_status_legal, clk, rst_n, out_valid, status_legal)
  `AST_SAME(a_short_zero, clk, rst_n, out_valid && out_status == mrcc_pkg::ST_SHORT, out_computed_crc == 16'h0000)
  `AST_SAME(a_in_open, clk, rst_n, in_valid && !out_valid, in_ready)

endmodule

bind modbus_rtu_frame_crc_check mrcc_checker u_mrcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_computed_crc (out_computed_crc)
);

`default_nettype wire

// ----- tb/sv/modbus_rtu_frame_crc_check_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Modbus RTU frame CRC check: byte stream in, status out.
// Depends on mrcc_pkg and modbus_rtu_frame_crc_check; stands alone otherwise.

module modbus_rtu_frame_crc_check_test;

  class crc_frame_scoreboard;
    logic [8:0]        byte_cnt;
    logic [7:0]        frame_len;
    logic [15:0]       crc_acc;
    logic [15:0]       crc_rx;
    mrcc_pkg::result_t verdicts[$];
    int                errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      byte_cnt  = '0;
      frame_len = '0;
      crc_acc   = mrcc_pkg::CRC_INIT;
      crc_rx    = '0;
    endfunction

    static function logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ mrcc_pkg::CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      int unsigned       pos;
      int unsigned       taken;
      logic [15:0]       swapped;
      mrcc_pkg::result_t verdict;
      pos = byte_cnt;
      if (pos == mrcc_pkg::LEN_POS) frame_len = b;
      if (pos <= mrcc_pkg::LEN_POS || pos < frame_len + mrcc_pkg::HDR_BYTES) begin
        crc_acc = fold_byte(crc_acc, b);
      end else if (pos == frame_len + mrcc_pkg::HDR_BYTES) begin
        crc_rx = {b, 8'h00};
      end else if (pos == frame_len + mrcc_pkg::HDR_BYTES + 1) begin
        crc_rx[7:0] = b;
      end
      if (byte_cnt != mrcc_pkg::CNT_MAX) byte_cnt++;
      if (last) begin
        taken = pos + 1;
        swapped = {crc_acc[7:0], crc_acc[15:8]};
        if (taken < mrcc_pkg::MIN_BYTES || taken < frame_len + mrcc_pkg::TAIL_BYTES) begin
          verdict.status = mrcc_pkg::ST_SHORT;
          verdict.computed_crc = 16'h0000;
        end else begin
          verdict.status = (swapped == crc_rx) ? mrcc_pkg::ST_OK : mrcc_pkg::ST_MISMATCH;
          verdict.computed_crc = swapped;
        end
        verdicts.push_back(verdict);
        clear();
      end
    endfunction

    function void check_result(input logic [1:0] status, input logic [15:0] crc);
      mrcc_pkg::result_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result, status %0d crc %h", $time, status, crc);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
      if (crc !== want.computed_crc) begin
        $display("%0t: crc expected %h, got %h", $time, want.computed_crc, crc);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_computed_crc;

  crc_frame_scoreboard board = new();
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;
  bit          calm = 1'b0;

  modbus_rtu_frame_crc_check dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_status, out_computed_crc);
    end
  end

  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, last);
    items_sent++;
  endtask

  task automatic send_buffer(ref logic [7:0] f[$]);
    calm = ($urandom_range(0, 3) == 0);
    foreach (f[k]) send_byte(f[k], k == f.size() - 1);
  endtask

  task automatic seal_frame(ref logic [7:0] f[$]);
    logic [15:0] c;
    c = mrcc_pkg::CRC_INIT;
    foreach (f[k]) c = crc_frame_scoreboard::fold_byte(c, f[k]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
  endtask

  task automatic build_frame(ref logic [7:0] f[$], input int unsigned len,
                             input int unsigned extra);
    f.delete();
    f.push_back(8'($urandom));
    f.push_back(8'($urandom));
    f.push_back(8'(len));
    repeat (len) f.push_back(8'($urandom));
    seal_frame(f);
    repeat (extra) f.push_back(8'($urandom));
  endtask

  initial begin
    logic [7:0]  f[$];
    int unsigned len;
    int unsigned kind;
    int unsigned cut;
    int unsigned idx;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    f = {8'hFF};
    send_buffer(f);
    f = {8'h00, 8'h00};
    send_buffer(f);
    f = {8'h01, 8'h03, 8'h00};
    send_buffer(f);
    f = {8'hFF, 8'hFF, 8'h00};
    seal_frame(f);
    send_buffer(f);
    f = {8'h00, 8'h00, 8'h00};
    seal_frame(f);
    f[4] = f[4] ^ 8'h80;
    send_buffer(f);
    f = {8'h11, 8'h22, 8'h01, 8'hAA};
    seal_frame(f);
    f.push_back(8'hFF);
    f.push_back(8'h00);
    send_buffer(f);
    f = {8'h01, 8'h02, 8'h02, 8'h33, 8'h44};
    seal_frame(f);
    void'(f.pop_back());
    send_buffer(f);

    // run the byte counter into saturation
    build_frame(f, 255, $urandom_range(256, 270));
    send_buffer(f);

    while (items_sent < 1450) begin
      quiet = (items_sent >= 1250);
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
      if (kind < 65) begin
        build_frame(f, len, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4));
      end else if (kind < 80) begin
        build_frame(f, len, 0);
        idx = $urandom_range(0, len + 4);
        f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 92) begin
        build_frame(f, len, 0);
        cut = $urandom_range(1, len + 4);
        while (f.size() > cut) void'(f.pop_back());
      end else begin
        f.delete();
        repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
      end
      send_buffer(f);
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
